@@ rtl/lrr_pkg.sv @@
// Shared types and constants for the LRU region replacement block.
// Holds index, time and link types, the entry layout and the action and state codes.
// No dependencies.
package lrr_pkg;

  localparam int NUM_REGIONS = 1024;
  localparam int REGION_BITS = $clog2(NUM_REGIONS);
  localparam int TIME_BITS   = 32;
  localparam int HIT_BITS    = 32;

  typedef logic [REGION_BITS-1:0] region_t;
  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [HIT_BITS-1:0]    hits_t;

  // A list link: the none flag marks the end of the list.
  typedef struct packed {
    logic    none;
    region_t idx;
  } link_t;

  localparam link_t LINK_NONE = '{none: 1'b1, idx: '0};

  typedef struct packed {
    link_t prev;
    link_t next;
  } links_t;

  typedef struct packed {
    logic  tracked;
    hits_t hits;
    time_t created;
    time_t accessed;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_TOUCH = 2'd0,
    ACT_TRACK = 2'd1,
    ACT_EVICT = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOVE_NEXT,
    S_MOVE_HEAD,
    S_MOVE_SELF,
    S_ATTACH
  } state_t;

endpackage

@@ rtl/lru_region_replacement.sv @@
// LRU replacement order over a fixed set of regions, kept as a doubly linked list.
// Depends on lrr_pkg for types, constants and codes.
// Usage: a request on the input channel (in_valid, in_stall; fields action,
// region, now_seconds) is taken at a rising edge where in_valid is high and
// in_stall is low. Touch, track and clear produce no result. Every evict
// produces exactly one result on the output channel (out_valid, out_stall;
// fields found, victim, victim_hits, age_since_create, age_since_access).
// An evict on an empty list returns all fields zero.
// Timing: the block handles one request at a time. Per-region state lives in
// two single-port synchronous memories: an entry memory (tracked flag, hit
// count, times) and a link memory (prev and next links, field-writable). The
// link memory takes one write per cycle, which sets the cost of relinking.
// From one accepted request to the next, a touch that moves a region to the
// head passes through exec, move-next, move-head and move-self; a track of a new
// region passes through exec and attach; a clear runs a pass over all 1024 regions;
// other requests return to idle after exec. The evict result is registered.
// Reset and stall: after reset a clearing pass over all 1024 entries zeroes the
// tracked flags while in_stall stays high. A clear request runs the same pass.
// The result register holds while out_stall is high; an evict that finds it
// still full waits in its final step, and new requests are taken once the
// block is back to idle, even with a result still waiting.
module lru_region_replacement (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  lrr_pkg::region_t    region,
  input  logic [31:0]         now_seconds,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output lrr_pkg::region_t    victim,
  output logic [31:0]         victim_hits,
  output logic [31:0]         age_since_create,
  output logic [31:0]         age_since_access
);

  // Control state.
  lrr_pkg::state_t  state, state_next;
  lrr_pkg::link_t   head, head_next;
  lrr_pkg::link_t   tail, tail_next;
  lrr_pkg::region_t clr_idx;

  // The request being worked on.
  lrr_pkg::action_t op;
  lrr_pkg::region_t cur;
  lrr_pkg::time_t   now_r;

  // Memories and their ports.
  lrr_pkg::entry_t  data_mem [lrr_pkg::NUM_REGIONS];
  lrr_pkg::links_t  link_mem [lrr_pkg::NUM_REGIONS];
  lrr_pkg::entry_t  data_rd;
  lrr_pkg::links_t  link_rd;
  logic             rd_en;
  lrr_pkg::region_t rd_addr;
  logic             data_we;
  lrr_pkg::region_t data_waddr;
  lrr_pkg::entry_t  data_wdata;
  logic             link_we_prev;
  logic             link_we_next;
  lrr_pkg::region_t link_waddr;
  lrr_pkg::link_t   link_wprev;
  lrr_pkg::link_t   link_wnext;

  // Result path.
  logic             out_free;
  logic             out_load;
  logic             res_found;
  lrr_pkg::time_t   age_create;
  lrr_pkg::time_t   age_access;
  lrr_pkg::link_t   self_link;

  assign out_free   = !out_valid || !out_stall;
  assign res_found  = !tail.none;
  assign age_create = now_r - data_rd.created;
  assign age_access = now_r - data_rd.accessed;
  assign self_link  = '{none: 1'b0, idx: cur};

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    in_stall     = 1'b1;
    rd_en        = 1'b0;
    rd_addr      = region;
    data_we      = 1'b0;
    data_waddr   = cur;
    data_wdata   = data_rd;
    link_we_prev = 1'b0;
    link_we_next = 1'b0;
    link_waddr   = cur;
    link_wprev   = lrr_pkg::LINK_NONE;
    link_wnext   = lrr_pkg::LINK_NONE;
    out_load     = 1'b0;

    unique case (state)
      lrr_pkg::S_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_idx;
        data_wdata = '0;
        if (clr_idx == lrr_pkg::REGION_BITS'(lrr_pkg::NUM_REGIONS - 1)) begin
          state_next = lrr_pkg::S_IDLE;
        end
      end

      lrr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (lrr_pkg::action_t'(action) == lrr_pkg::ACT_CLEAR) begin
            head_next  = lrr_pkg::LINK_NONE;
            tail_next  = lrr_pkg::LINK_NONE;
            state_next = lrr_pkg::S_CLEAR;
          end else begin
            rd_en      = 1'b1;
            if (lrr_pkg::action_t'(action) == lrr_pkg::ACT_EVICT) begin
              rd_addr = tail.idx;
            end
            state_next = lrr_pkg::S_EXEC;
          end
        end
      end

      lrr_pkg::S_EXEC: begin
        case (op)
          lrr_pkg::ACT_TOUCH: begin
            if (!data_rd.tracked) begin
              state_next = lrr_pkg::S_IDLE;
            end else begin
              data_we             = 1'b1;
              data_wdata.hits     = data_rd.hits + 1'b1;
              data_wdata.accessed = now_r;
              if (link_rd.prev.none) begin
                // Already at the head: the order does not change.
                state_next = lrr_pkg::S_IDLE;
              end else begin
                link_we_next = 1'b1;
                link_waddr   = link_rd.prev.idx;
                link_wnext   = link_rd.next;
                state_next   = lrr_pkg::S_MOVE_NEXT;
              end
            end
          end
          lrr_pkg::ACT_TRACK: begin
            data_we    = 1'b1;
            data_wdata = '{tracked: 1'b1, hits: '0, created: now_r, accessed: now_r};
            if (data_rd.tracked) begin
              // Re-tracking keeps the region's place in the list.
              state_next = lrr_pkg::S_IDLE;
            end else begin
              link_we_prev = 1'b1;
              link_we_next = 1'b1;
              link_wprev   = lrr_pkg::LINK_NONE;
              link_wnext   = head;
              state_next   = lrr_pkg::S_ATTACH;
            end
          end
          lrr_pkg::ACT_EVICT: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = lrr_pkg::S_IDLE;
              if (res_found) begin
                data_we            = 1'b1;
                data_wdata.tracked = 1'b0;
                tail_next          = link_rd.prev;
                if (link_rd.prev.none) begin
                  head_next = lrr_pkg::LINK_NONE;
                end else begin
                  link_we_next = 1'b1;
                  link_waddr   = link_rd.prev.idx;
                  link_wnext   = lrr_pkg::LINK_NONE;
                end
              end
            end
          end
          default: begin
            state_next = lrr_pkg::S_IDLE;
          end
        endcase
      end

      lrr_pkg::S_MOVE_NEXT: begin
        // Close the gap behind the moved region.
        if (link_rd.next.none) begin
          tail_next = link_rd.prev;
        end else begin
          link_we_prev = 1'b1;
          link_waddr   = link_rd.next.idx;
          link_wprev   = link_rd.prev;
        end
        state_next = lrr_pkg::S_MOVE_HEAD;
      end

      lrr_pkg::S_MOVE_HEAD: begin
        // The list holds at least the predecessor, so the head is valid here.
        link_we_prev = 1'b1;
        link_waddr   = head.idx;
        link_wprev   = self_link;
        state_next   = lrr_pkg::S_MOVE_SELF;
      end

      lrr_pkg::S_MOVE_SELF: begin
        link_we_prev = 1'b1;
        link_we_next = 1'b1;
        link_wprev   = lrr_pkg::LINK_NONE;
        link_wnext   = head;
        head_next    = self_link;
        state_next   = lrr_pkg::S_IDLE;
      end

      lrr_pkg::S_ATTACH: begin
        if (head.none) begin
          tail_next = self_link;
        end else begin
          link_we_prev = 1'b1;
          link_waddr   = head.idx;
          link_wprev   = self_link;
        end
        head_next  = self_link;
        state_next = lrr_pkg::S_IDLE;
      end

      default: begin
        state_next = lrr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lrr_pkg::S_CLEAR;
      head    <= lrr_pkg::LINK_NONE;
      tail    <= lrr_pkg::LINK_NONE;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (state == lrr_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end else begin
        clr_idx <= '0;
      end
    end
  end

  // Request registers; they load only when a request is taken.
  always_ff @(posedge clk) begin
    if (state == lrr_pkg::S_IDLE && in_valid) begin
      op    <= lrr_pkg::action_t'(action);
      cur   <= rd_addr;
      now_r <= lrr_pkg::time_t'(now_seconds);
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (rd_en) begin
      data_rd <= data_mem[rd_addr];
    end
  end

  // Link memory with separate writes for the two link fields.
  always_ff @(posedge clk) begin
    if (link_we_prev) begin
      link_mem[link_waddr].prev <= link_wprev;
    end
    if (link_we_next) begin
      link_mem[link_waddr].next <= link_wnext;
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found            <= res_found;
      victim           <= res_found ? tail.idx : '0;
      victim_hits      <= res_found ? 32'(data_rd.hits) : '0;
      age_since_create <= res_found ? 32'(age_create) : '0;
      age_since_access <= res_found ? 32'(age_access) : '0;
    end
  end

endmodule

@@ tb/tb_lru_region_replacement.sv @@
// Self-checking testbench for the LRU region replacement block.
// Drives touch, track, evict and clear requests and checks every eviction result
// against a linked-list predictor kept in a scoreboard class. Depends on lrr_pkg.
module tb_lru_region_replacement;
  import lrr_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 12;
  // The slowest legal gap is a clear pass, possibly behind a long receiver
  // hold-off, so the limit is set well above the two together.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_PCT       = 13;
  localparam int HOT_SET        = 12;

  // A list slot is one bit wider than a region index; NUM_REGIONS means none.
  typedef logic [REGION_BITS:0] slot_t;
  localparam slot_t NO_SLOT = slot_t'(NUM_REGIONS);

  typedef struct packed {
    logic    found;
    region_t victim;
    hits_t   hits;
    time_t   age_create;
    time_t   age_access;
  } victim_t;

  // The scoreboard keeps its own copy of the LRU order and queues the eviction
  // result that each accepted evict request is due to produce.
  class victim_scoreboard;
    slot_t   prev_of[NUM_REGIONS];
    slot_t   next_of[NUM_REGIONS];
    bit      listed[NUM_REGIONS];
    hits_t   hits[NUM_REGIONS];
    time_t   born[NUM_REGIONS];
    time_t   last_use[NUM_REGIONS];
    slot_t   head;
    slot_t   tail;
    victim_t victims_due[$];
    int      errors;

    function new();
      foreach (hits[k]) begin
        hits[k]     = '0;
        born[k]     = '0;
        last_use[k] = '0;
      end
      empty_order();
      errors = 0;
    endfunction

    function void empty_order();
      foreach (listed[k]) begin
        prev_of[k] = NO_SLOT;
        next_of[k] = NO_SLOT;
        listed[k]  = 1'b0;
      end
      head = NO_SLOT;
      tail = NO_SLOT;
    endfunction

    function void unlink_region(region_t r);
      slot_t p;
      slot_t n;
      p = prev_of[r];
      n = next_of[r];
      if (n != NO_SLOT) prev_of[n] = p;
      else tail = p;
      if (p != NO_SLOT) next_of[p] = n;
      else head = n;
      prev_of[r] = NO_SLOT;
      next_of[r] = NO_SLOT;
    endfunction

    function void link_at_head(region_t r);
      prev_of[r] = NO_SLOT;
      next_of[r] = head;
      if (head != NO_SLOT) prev_of[head] = slot_t'(r);
      else tail = slot_t'(r);
      head = slot_t'(r);
    endfunction

    function bit is_listed(region_t r);
      return listed[r];
    endfunction

    function int outstanding();
      return victims_due.size();
    endfunction

    // Called once for every request the block accepts.
    function void note_request(action_t a, region_t r, time_t t);
      victim_t v;
      case (a)
        ACT_TOUCH: begin
          if (listed[r]) begin
            hits[r]     = hits[r] + 1'b1;
            last_use[r] = t;
            unlink_region(r);
            link_at_head(r);
          end
        end
        ACT_TRACK: begin
          // A region already in the list is refreshed but keeps its place.
          hits[r]     = '0;
          born[r]     = t;
          last_use[r] = t;
          if (!listed[r]) begin
            listed[r] = 1'b1;
            link_at_head(r);
          end
        end
        ACT_EVICT: begin
          v = '0;
          if (tail != NO_SLOT) begin
            v.found      = 1'b1;
            v.victim     = tail[REGION_BITS-1:0];
            v.hits       = hits[v.victim];
            v.age_create = t - born[v.victim];
            v.age_access = t - last_use[v.victim];
            unlink_region(v.victim);
            listed[v.victim] = 1'b0;
          end
          victims_due.push_back(v);
        end
        ACT_CLEAR: begin
          empty_order();
        end
      endcase
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(victim_t got);
      victim_t want;
      if (victims_due.size() == 0) begin
        errors++;
        $display("%0t: result with no evict pending: expected none, actual victim %0d",
                 $time, got.victim);
        return;
      end
      want = victims_due.pop_front();
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("victim", 32'(want.victim), 32'(got.victim));
      compare_field("victim_hits", want.hits, got.hits);
      compare_field("age_since_create", want.age_create, got.age_create);
      compare_field("age_since_access", want.age_access, got.age_access);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TOUCH;
  region_t     region = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  region_t     victim;
  logic [31:0] victim_hits;
  logic [31:0] age_since_create;
  logic [31:0] age_since_access;

  victim_scoreboard sb = new();

  // Random idling on both sides is switched off for one long stretch.
  bit      idle_on = 1'b1;
  // Set by the stimulus to make the receiver hold off for HOLD_CYCLES.
  bit      hold_req = 1'b0;
  int      quiet_cycles = 0;
  time_t   wall_s = '0;
  region_t hot[HOT_SET];

  lru_region_replacement dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .region           (region),
    .now_seconds      (now_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .victim           (victim),
    .victim_hits      (victim_hits),
    .age_since_create (age_since_create),
    .age_since_access (age_since_access)
  );

  always #HALF_PERIOD clk = ~clk;

  // Every accepted result is checked against the oldest pending eviction.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result('{found, victim, victim_hits, age_since_create, age_since_access});
    end
  end

  // Count cycles in which neither channel moves anything; the watchdog below
  // ends the run if the block stops making progress.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("lru_region_replacement test failed");
    $finish;
  end

  // Receiver. It stalls at random, and on request holds off for a long stretch
  // so that a result sits in the output register and later evicts back up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one request and wait for it to be accepted. The payload is set at a
  // falling edge and held until a rising edge sees in_stall low.
  task automatic send_request(action_t a, region_t r, time_t t);
    @(negedge clk);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= a;
    region      <= r;
    now_seconds <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(a, r, t);
  endtask

  // Drop valid and wait until every pending eviction has been returned.
  task automatic wait_for_victims();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Time mostly creeps forward; now and then it jumps anywhere or to just
  // below the wrap point, so that ages wrap around.
  task automatic advance_wall();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) wall_s = $urandom();
    else if (roll < 3) wall_s = 32'hFFFF_FFFF - $urandom_range(8);
    else wall_s = wall_s + $urandom_range(3);
  endtask

  // Most requests hit a small working set so that touches find tracked
  // regions and the list stays short enough to be emptied often.
  function automatic region_t pick_region();
    if ($urandom_range(99) < 85) return hot[$urandom_range(HOT_SET - 1)];
    return region_t'($urandom_range(NUM_REGIONS - 1));
  endfunction

  // Random requests; every request sent counts toward the total, including
  // touches of regions not in the list, which the block ignores.
  task automatic run_random(int count, int evict_pct);
    int      done;
    int      roll;
    action_t a;
    region_t r;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(999);
      r    = pick_region();
      if (roll < 7) a = ACT_CLEAR;
      else if (roll < 7 + evict_pct * 10) a = ACT_EVICT;
      else if ($urandom_range(99) < 35) a = ACT_TRACK;
      else a = ACT_TOUCH;
      done++;
      advance_wall();
      send_request(a, r, wall_s);
      if ($urandom_range(99) == 0) begin
        hot[$urandom_range(HOT_SET - 1)] = region_t'($urandom_range(NUM_REGIONS - 1));
      end
    end
  endtask

  initial begin
    foreach (hot[k]) hot[k] = region_t'($urandom_range(NUM_REGIONS - 1));
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Evict on an empty list, touch of an untracked region,
    // re-track of a tracked region, head touches, index and time extremes,
    // ages that wrap, and a clear followed by use of the cleared regions.
    send_request(ACT_EVICT, 10'd0,     32'd0);
    send_request(ACT_TOUCH, 10'd0,     32'd0);
    send_request(ACT_TRACK, 10'd0,     32'd0);
    send_request(ACT_TRACK, 10'd1023,  32'hFFFF_FFFF);
    send_request(ACT_TRACK, 10'd512,   32'd5);
    send_request(ACT_TOUCH, 10'd0,     32'd100);
    send_request(ACT_TOUCH, 10'd0,     32'd101);
    send_request(ACT_TRACK, 10'd1023,  32'd7);
    send_request(ACT_TOUCH, 10'd1023,  32'hFFFF_FFF0);
    send_request(ACT_EVICT, 10'd0,     32'd3);
    send_request(ACT_EVICT, 10'd1023,  32'd200);
    send_request(ACT_EVICT, 10'd0,     32'd0);
    send_request(ACT_EVICT, 10'd0,     32'd9);
    send_request(ACT_TRACK, 10'h155,   32'd10);
    send_request(ACT_TRACK, 10'h2AA,   32'd11);
    send_request(ACT_CLEAR, 10'h3FF,   32'd12);
    send_request(ACT_EVICT, 10'd0,     32'd13);
    send_request(ACT_TOUCH, 10'h155,   32'd14);
    send_request(ACT_TRACK, 10'h2AA,   32'd15);
    send_request(ACT_TOUCH, 10'h2AA,   32'hFFFF_FFFF);
    send_request(ACT_EVICT, 10'd0,     32'd16);
    wall_s = 32'd16;

    run_random(500, 25);

    // The sender pauses here until the block has returned every eviction.
    wait_for_victims();

    // Long receiver hold-off while evict-heavy traffic keeps coming, so the
    // result register fills and the block stalls its input.
    hold_req = 1'b1;
    run_random(60, 70);
    wait_for_victims();

    // A long stretch with no idling on either side.
    idle_on = 1'b0;
    run_random(500, 25);
    idle_on = 1'b1;

    run_random(490, 25);
    wait_for_victims();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("lru_region_replacement test passed");
    end else begin
      $display("lru_region_replacement test failed");
    end
    $finish;
  end

endmodule
